// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the collision block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/scpn_pkg.sv -----
// ---------------------------------------------------------------------------
// scpn_pkg
// Types and constants for the segment collision point and normal block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpn_pkg;

    localparam int COORD_W           = 32;
    localparam int NORM_W            = 16;
    localparam int NORM_STEPS        = 2 * (NORM_W - 1);
    localparam int FRACTION_BITS_DEF = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] wall_start_x;
        logic signed [COORD_W-1:0] wall_start_y;
        logic signed [COORD_W-1:0] wall_end_x;
        logic signed [COORD_W-1:0] wall_end_y;
    } scpn_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] impact_x;
        logic signed [COORD_W-1:0] impact_y;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
    } scpn_rsp_t;

endpackage

// ----- rtl/scpn_frac_div.sv -----
// ---------------------------------------------------------------------------
// scpn_frac_div
// Pipelined restoring divider, one quotient bit per stage:
// quo = floor(num * 2^STEPS / den), followed by pad registers when LAT exceeds STEPS + 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpn_frac_div #(
    parameter int DEN_W = 67,
    parameter int STEPS = 32,
    parameter int LAT   = 33
) (
    input  logic             clk,
    input  logic [DEN_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [STEPS:0]   quo
);

    localparam int RW  = DEN_W + 1;
    localparam int PAD = LAT - STEPS - 1;

    logic [RW-1:0]    rem_reg [0:STEPS-1];
    logic [DEN_W-1:0] den_reg [0:STEPS-1];
    logic [STEPS:0]   quo_reg [0:STEPS];

    logic [RW-1:0] rem0;
    logic          ge0;

    assign rem0 = {1'b0, num};
    assign ge0  = rem0 >= {1'b0, den};

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ge0 ? rem0 - {1'b0, den} : rem0;
        den_reg[0] <= den;
        quo_reg[0] <= {{STEPS{1'b0}}, ge0};
    end

    for (genvar i = 1; i <= STEPS; i++)
    begin : g_step
        logic [RW-1:0] shl;
        logic          ge;

        assign shl = {rem_reg[i-1][RW-2:0], 1'b0};
        assign ge  = shl >= {1'b0, den_reg[i-1]};

        always_ff @(posedge clk)
        begin
            quo_reg[i] <= {quo_reg[i-1][STEPS-1:0], ge};
        end

        if (i < STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= ge ? shl - {1'b0, den_reg[i-1]} : shl;
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    if (PAD > 0)
    begin : g_pad
        logic [STEPS:0] pad_reg [0:PAD-1];

        always_ff @(posedge clk)
        begin
            pad_reg[0] <= quo_reg[STEPS];
            for (int p = 1; p < PAD; p++)
            begin
                pad_reg[p] <= pad_reg[p-1];
            end
        end

        assign quo = pad_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign quo = quo_reg[STEPS];
    end

endmodule

// ----- rtl/segment_collision_point_normal.sv -----
// Throughput: one transfer per cycle; busy is always low, results never stall.
// Depth is set by the bit-per-stage fraction divider and the 16-stage square root.
// Reset clears all valid bits at once; no result is issued for items in flight.
// ---------------------------------------------------------------------------
// segment_collision_point_normal
// Segment against wall crossing test with impact point and unit wall normal.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_collision_point_normal
    import scpn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  scpn_req_t req,
    output logic      done,
    output scpn_rsp_t rsp
);

    localparam int W       = COORD_W;
    localparam int DW      = W + 1;
    localparam int PW      = 2 * DW;
    localparam int CW      = PW + 1;
    localparam int K_BITS  = 2 * FRACTION_BITS;
    localparam int KQ_W    = K_BITS + 1;
    localparam int NQ_W    = NORM_STEPS + 1;
    localparam int DIV_LAT = ((K_BITS > NORM_STEPS) ? K_BITS : NORM_STEPS) + 1;
    localparam int SQ      = NORM_W;
    localparam int MW      = KQ_W + DW;
    localparam int SW      = MW + 1 - K_BITS;
    localparam int VW      = SW + 2;

    localparam int C_S1  = 0;
    localparam int C_S2  = 1;
    localparam int C_S3  = 2;
    localparam int C_S4  = 3;
    localparam int C_DET = 4;
    localparam int C_NUM = 5;

    localparam logic [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};

    typedef struct packed {
        logic                 hit;
        logic                 det_pos;
        logic                 wall_nz;
        logic                 nx_neg;
        logic                 ny_neg;
        logic signed [W-1:0]  ax;
        logic signed [W-1:0]  ay;
        logic signed [DW-1:0] abx;
        logic signed [DW-1:0] aby;
    } side_t;

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, vm_reg, done_reg;
    logic vd_reg [0:DIV_LAT-1];
    logic vs_reg [0:SQ-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
            for (int i = 0; i < SQ; i++)
            begin
                vs_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            vs_reg[0] <= vd_reg[DIV_LAT-1];
            for (int i = 1; i < SQ; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
            end
            vm_reg   <= vs_reg[SQ-1];
            done_reg <= vm_reg;
        end
    end

    assign busy = 1'b0;

    // stage 1: differences
    logic signed [W-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0] abx1_reg, aby1_reg, opx1_reg, opy1_reg, aox1_reg, aoy1_reg;
    logic signed [DW-1:0] pax1_reg, pay1_reg, oax1_reg, oay1_reg, obx1_reg, oby1_reg;
    logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, ox_e, oy_e, px_e, py_e;

    assign ax_e = DW'(req.start_x);
    assign ay_e = DW'(req.start_y);
    assign bx_e = DW'(req.end_x);
    assign by_e = DW'(req.end_y);
    assign ox_e = DW'(req.wall_start_x);
    assign oy_e = DW'(req.wall_start_y);
    assign px_e = DW'(req.wall_end_x);
    assign py_e = DW'(req.wall_end_y);

    always_ff @(posedge clk)
    begin
        ax1_reg  <= req.start_x;
        ay1_reg  <= req.start_y;
        abx1_reg <= bx_e - ax_e;
        aby1_reg <= by_e - ay_e;
        opx1_reg <= px_e - ox_e;
        opy1_reg <= py_e - oy_e;
        aox1_reg <= ox_e - ax_e;
        aoy1_reg <= oy_e - ay_e;
        pax1_reg <= px_e - ax_e;
        pay1_reg <= py_e - ay_e;
        oax1_reg <= ax_e - ox_e;
        oay1_reg <= ay_e - oy_e;
        obx1_reg <= bx_e - ox_e;
        oby1_reg <= by_e - oy_e;
    end

    // stage 2: products
    logic signed [PW-1:0] pa2_reg [0:5];
    logic signed [PW-1:0] pb2_reg [0:5];
    logic signed [PW-1:0] sqx2_reg, sqy2_reg;
    logic signed [W-1:0]  ax2_reg, ay2_reg;
    logic signed [DW-1:0] abx2_reg, aby2_reg, aox2_reg, aoy2_reg;
    logic                 nxn2_reg, nyn2_reg, wnz2_reg;

    always_ff @(posedge clk)
    begin
        pa2_reg[C_S1]  <= abx1_reg * aoy1_reg;
        pb2_reg[C_S1]  <= aby1_reg * aox1_reg;
        pa2_reg[C_S2]  <= abx1_reg * pay1_reg;
        pb2_reg[C_S2]  <= aby1_reg * pax1_reg;
        pa2_reg[C_S3]  <= opx1_reg * oay1_reg;
        pb2_reg[C_S3]  <= opy1_reg * oax1_reg;
        pa2_reg[C_S4]  <= opx1_reg * oby1_reg;
        pb2_reg[C_S4]  <= opy1_reg * obx1_reg;
        pa2_reg[C_DET] <= abx1_reg * opy1_reg;
        pb2_reg[C_DET] <= aby1_reg * opx1_reg;
        pa2_reg[C_NUM] <= aox1_reg * opy1_reg;
        pb2_reg[C_NUM] <= aoy1_reg * opx1_reg;
        sqx2_reg       <= opx1_reg * opx1_reg;
        sqy2_reg       <= opy1_reg * opy1_reg;
        ax2_reg        <= ax1_reg;
        ay2_reg        <= ay1_reg;
        abx2_reg       <= abx1_reg;
        aby2_reg       <= aby1_reg;
        aox2_reg       <= aox1_reg;
        aoy2_reg       <= aoy1_reg;
        nxn2_reg       <= opy1_reg[DW-1];
        nyn2_reg       <= !opx1_reg[DW-1] && (opx1_reg != '0);
        wnz2_reg       <= (opx1_reg != '0) || (opy1_reg != '0);
    end

    // stage 3: cross products and wall length squared
    logic signed [CW-1:0] cr3_reg [0:5];
    logic [CW-1:0]        len3_reg, sqx3_reg, sqy3_reg;
    logic signed [W-1:0]  ax3_reg, ay3_reg;
    logic signed [DW-1:0] abx3_reg, aby3_reg, aox3_reg, aoy3_reg;
    logic                 nxn3_reg, nyn3_reg, wnz3_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            cr3_reg[j] <= CW'(pa2_reg[j]) - CW'(pb2_reg[j]);
        end
        len3_reg <= CW'(sqx2_reg) + CW'(sqy2_reg);
        sqx3_reg <= CW'(sqx2_reg);
        sqy3_reg <= CW'(sqy2_reg);
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        abx3_reg <= abx2_reg;
        aby3_reg <= aby2_reg;
        aox3_reg <= aox2_reg;
        aoy3_reg <= aoy2_reg;
        nxn3_reg <= nxn2_reg;
        nyn3_reg <= nyn2_reg;
        wnz3_reg <= wnz2_reg;
    end

    // stage 4: side tests, fraction operands, hit
    logic [5:0]           cneg, cnz;
    logic                 ok12, ok34, hit4;
    logic signed [CW-1:0] num_sel, den_sel, num_pos, den_pos;
    logic [CW-1:0]        num4_reg, den4_reg, len4_reg, cx4_reg, cy4_reg;
    side_t                side4_reg;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            cneg[j] = cr3_reg[j][CW-1];
            cnz[j]  = |cr3_reg[j];
        end
        ok12 = !(cnz[C_S1] && cnz[C_S2] && (cneg[C_S1] == cneg[C_S2]));
        ok34 = !(cnz[C_S3] && cnz[C_S4] && (cneg[C_S3] == cneg[C_S4]));
        if (cnz[C_DET])
        begin
            num_sel = cr3_reg[C_NUM];
            den_sel = cr3_reg[C_DET];
        end
        else if (abx3_reg != '0)
        begin
            num_sel = CW'(aox3_reg);
            den_sel = CW'(abx3_reg);
        end
        else if (aby3_reg != '0)
        begin
            num_sel = CW'(aoy3_reg);
            den_sel = CW'(aby3_reg);
        end
        else
        begin
            num_sel = '0;
            den_sel = {{(CW-1){1'b0}}, 1'b1};
        end
        if (den_sel[CW-1])
        begin
            num_pos = -num_sel;
            den_pos = -den_sel;
        end
        else
        begin
            num_pos = num_sel;
            den_pos = den_sel;
        end
        hit4 = ok12 && ok34 && !num_pos[CW-1] && (num_pos <= den_pos);
    end

    always_ff @(posedge clk)
    begin
        num4_reg          <= num_pos;
        den4_reg          <= den_pos;
        len4_reg          <= len3_reg;
        cx4_reg           <= sqy3_reg;
        cy4_reg           <= sqx3_reg;
        side4_reg.hit     <= hit4;
        side4_reg.det_pos <= cnz[C_DET] && !cneg[C_DET];
        side4_reg.wall_nz <= wnz3_reg;
        side4_reg.nx_neg  <= nxn3_reg;
        side4_reg.ny_neg  <= nyn3_reg;
        side4_reg.ax      <= ax3_reg;
        side4_reg.ay      <= ay3_reg;
        side4_reg.abx     <= abx3_reg;
        side4_reg.aby     <= aby3_reg;
    end

    // dividers
    logic [KQ_W-1:0] kq_d;
    logic [NQ_W-1:0] qx_d, qy_d;
    side_t           sd_reg [0:DIV_LAT-1];

    scpn_frac_div #(.DEN_W(CW), .STEPS(K_BITS), .LAT(DIV_LAT)) u_div_k (
        .clk (clk),
        .num (num4_reg),
        .den (den4_reg),
        .quo (kq_d)
    );

    scpn_frac_div #(.DEN_W(CW), .STEPS(NORM_STEPS), .LAT(DIV_LAT)) u_div_nx (
        .clk (clk),
        .num (cx4_reg),
        .den (len4_reg),
        .quo (qx_d)
    );

    scpn_frac_div #(.DEN_W(CW), .STEPS(NORM_STEPS), .LAT(DIV_LAT)) u_div_ny (
        .clk (clk),
        .num (cy4_reg),
        .den (len4_reg),
        .quo (qy_d)
    );

    always_ff @(posedge clk)
    begin
        sd_reg[0] <= side4_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            sd_reg[i] <= sd_reg[i-1];
        end
    end

    // square root, one result bit per stage
    logic [NORM_W-1:0] rx_reg [0:SQ-1];
    logic [NORM_W-1:0] ry_reg [0:SQ-1];
    logic [NQ_W-1:0]   qx_reg [0:SQ-2];
    logic [NQ_W-1:0]   qy_reg [0:SQ-2];
    logic [KQ_W-1:0]   kq_reg [0:SQ-1];
    side_t             ss_reg [0:SQ-1];

    for (genvar j = 0; j < SQ; j++)
    begin : g_sqrt
        localparam int BIT = SQ - 1 - j;

        logic [NORM_W-1:0]   rx_in, ry_in, tx, ty;
        logic [2*NORM_W-1:0] tx_sq, ty_sq;
        logic [NQ_W-1:0]     qx_in, qy_in;
        logic [KQ_W-1:0]     kq_in;
        side_t               s_in;

        if (j == 0)
        begin : g_first
            assign rx_in = '0;
            assign ry_in = '0;
            assign qx_in = qx_d;
            assign qy_in = qy_d;
            assign kq_in = kq_d;
            assign s_in  = sd_reg[DIV_LAT-1];
        end
        else
        begin : g_next
            assign rx_in = rx_reg[j-1];
            assign ry_in = ry_reg[j-1];
            assign qx_in = qx_reg[j-1];
            assign qy_in = qy_reg[j-1];
            assign kq_in = kq_reg[j-1];
            assign s_in  = ss_reg[j-1];
        end

        assign tx    = rx_in | (NORM_W'(1) << BIT);
        assign ty    = ry_in | (NORM_W'(1) << BIT);
        assign tx_sq = tx * tx;
        assign ty_sq = ty * ty;

        always_ff @(posedge clk)
        begin
            rx_reg[j] <= (tx_sq <= (2*NORM_W)'(qx_in)) ? tx : rx_in;
            ry_reg[j] <= (ty_sq <= (2*NORM_W)'(qy_in)) ? ty : ry_in;
            kq_reg[j] <= kq_in;
            ss_reg[j] <= s_in;
        end

        if (j < SQ - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                qx_reg[j] <= qx_in;
                qy_reg[j] <= qy_in;
            end
        end
    end

    // impact multiply and normal sign
    side_t                    sl;
    logic [NORM_W-1:0]        mx, my;
    logic signed [NORM_W-1:0] nx_sel, ny_sel;
    logic [DW-1:0]            magx, magy;
    logic [MW-1:0]            prodx_reg, prody_reg;
    logic signed [NORM_W-1:0] nx_m_reg, ny_m_reg;
    logic signed [W-1:0]      ax_m_reg, ay_m_reg;
    logic                     dxn_m_reg, dyn_m_reg, hit_m_reg;

    assign sl   = ss_reg[SQ-1];
    assign mx   = rx_reg[SQ-1][NORM_W-1] ? NORM_MAX : rx_reg[SQ-1];
    assign my   = ry_reg[SQ-1][NORM_W-1] ? NORM_MAX : ry_reg[SQ-1];
    assign magx = sl.abx[DW-1] ? DW'(-sl.abx) : DW'(sl.abx);
    assign magy = sl.aby[DW-1] ? DW'(-sl.aby) : DW'(sl.aby);

    always_comb
    begin
        nx_sel = '0;
        ny_sel = '0;
        if (sl.wall_nz)
        begin
            nx_sel = (sl.nx_neg ^ sl.det_pos) ? -$signed(mx) : $signed(mx);
            ny_sel = (sl.ny_neg ^ sl.det_pos) ? -$signed(my) : $signed(my);
        end
    end

    always_ff @(posedge clk)
    begin
        prodx_reg <= MW'(kq_reg[SQ-1]) * MW'(magx);
        prody_reg <= MW'(kq_reg[SQ-1]) * MW'(magy);
        nx_m_reg  <= nx_sel;
        ny_m_reg  <= ny_sel;
        ax_m_reg  <= sl.ax;
        ay_m_reg  <= sl.ay;
        dxn_m_reg <= sl.abx[DW-1];
        dyn_m_reg <= sl.aby[DW-1];
        hit_m_reg <= sl.hit;
    end

    // round, offset, saturate
    localparam logic [MW:0] HALF = (MW + 1)'(1) << (K_BITS - 1);

    logic [MW:0]          sumx, sumy;
    logic signed [VW-1:0] sxv, syv, vx, vy;
    logic [W-1:0]         resx, resy;
    scpn_rsp_t            rsp_reg;

    assign sumx = {1'b0, prodx_reg} + HALF;
    assign sumy = {1'b0, prody_reg} + HALF;
    assign sxv  = VW'({1'b0, sumx[MW:K_BITS]});
    assign syv  = VW'({1'b0, sumy[MW:K_BITS]});
    assign vx   = VW'(ax_m_reg) + (dxn_m_reg ? -sxv : sxv);
    assign vy   = VW'(ay_m_reg) + (dyn_m_reg ? -syv : syv);

    always_comb
    begin
        if ((&vx[VW-1:W-1]) || !(|vx[VW-1:W-1]))
        begin
            resx = vx[W-1:0];
        end
        else
        begin
            resx = vx[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if ((&vy[VW-1:W-1]) || !(|vy[VW-1:W-1]))
        begin
            resy = vy[W-1:0];
        end
        else
        begin
            resy = vy[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.hit      <= hit_m_reg;
        rsp_reg.impact_x <= hit_m_reg ? resx : '0;
        rsp_reg.impact_y <= hit_m_reg ? resy : '0;
        rsp_reg.normal_x <= hit_m_reg ? nx_m_reg : '0;
        rsp_reg.normal_y <= hit_m_reg ? ny_m_reg : '0;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, done && !rsp.hit, (rsp.impact_x == '0) && (rsp.impact_y == '0) && (rsp.normal_x == '0) && (rsp.normal_y == '0))
    `ASSERT_IMPLIES(a_norm_range, clk, rst_n, done, !(rsp.normal_x[NORM_W-1] && (rsp.normal_x[NORM_W-2:0] == '0)) && !(rsp.normal_y[NORM_W-1] && (rsp.normal_y[NORM_W-2:0] == '0)))
    `ASSERT_NEXT(a_out_follows, clk, rst_n, vm_reg, done)

endmodule

// ----- verif/tb_segment_collision_point_normal.sv -----
// ---------------------------------------------------------------------------
// tb_segment_collision_point_normal
// Feeds segment and wall pairs into the collision block and compares each
// result with a predictor of the crossing test, the impact point and the
// unit wall normal. The random pairs favour real crossings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_collision_point_normal;
    import scpn_pkg::*;

    localparam int KB = 2 * FRACTION_BITS_DEF;
    localparam int WATCHDOG = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    scpn_req_t req;
    logic      done;
    scpn_rsp_t rsp;

    scpn_req_t pending_pairs[$];
    scpn_rsp_t expected_hits[$];
    int        errors;
    int        n_sent;
    int        n_hits;
    int        idle_cnt;
    bit        stim_done;
    bit        calm;

    segment_collision_point_normal dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [127:0] cross2(logic signed [127:0] ux,
        logic signed [127:0] uy, logic signed [127:0] vx, logic signed [127:0] vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic int sgn(logic signed [127:0] v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] unit_comp(logic signed [127:0] c,
        logic signed [127:0] len2);
        logic [127:0] q;
        logic [63:0]  m;
        q = ((c * c) << 30) / len2;
        m = sqrt_floor(q[63:0]);
        if (m > 32767)
            m = 32767;
        return (c < 0) ? -$signed(m[15:0]) : $signed(m[15:0]);
    endfunction

    function automatic logic signed [31:0] impact_at(logic signed [127:0] a,
        logic signed [127:0] d, logic [127:0] kq);
        logic [127:0]        md;
        logic [127:0]        s;
        logic signed [127:0] v;
        md = (d < 0) ? -d : d;
        s = (kq * md + (128'd1 << (KB - 1))) >> KB;
        v = (d < 0) ? a - $signed(s) : a + $signed(s);
        if (v > 128'sd2147483647)
            v = 128'sd2147483647;
        if (v < -128'sd2147483648)
            v = -128'sd2147483648;
        return v[31:0];
    endfunction

    function automatic scpn_rsp_t predict_collision(scpn_req_t p);
        logic signed [127:0] ax, ay, bx, by, ox, oy, px, py;
        logic signed [127:0] abx, aby, opx, opy, aox, aoy;
        logic signed [127:0] det, num, den, len2;
        logic [127:0]        kq;
        int                  s1, s2, s3, s4;
        scpn_rsp_t           r;
        ax = p.start_x;      ay = p.start_y;
        bx = p.end_x;        by = p.end_y;
        ox = p.wall_start_x; oy = p.wall_start_y;
        px = p.wall_end_x;   py = p.wall_end_y;
        abx = bx - ax; aby = by - ay; opx = px - ox; opy = py - oy;
        aox = ox - ax; aoy = oy - ay;
        s1 = sgn(cross2(abx, aby, aox, aoy));
        s2 = sgn(cross2(abx, aby, px - ax, py - ay));
        s3 = sgn(cross2(opx, opy, ax - ox, ay - oy));
        s4 = sgn(cross2(opx, opy, bx - ox, by - oy));
        det = cross2(abx, aby, opx, opy);
        if (det != 0)
        begin
            num = cross2(aox, aoy, opx, opy);
            den = det;
        end
        else if (abx != 0)
        begin
            num = aox;
            den = abx;
        end
        else if (aby != 0)
        begin
            num = aoy;
            den = aby;
        end
        else
        begin
            num = 0;
            den = 1;
        end
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        r = '0;
        if (!(s1 * s2 <= 0 && s3 * s4 <= 0 && num >= 0 && num <= den))
            return r;
        kq = (num << KB) / den;
        r.hit = 1'b1;
        r.impact_x = impact_at(ax, abx, kq);
        r.impact_y = impact_at(ay, aby, kq);
        if (opx != 0 || opy != 0)
        begin
            len2 = opx * opx + opy * opy;
            r.normal_x = unit_comp(opy, len2);
            r.normal_y = unit_comp(-opx, len2);
            if (det > 0)
            begin
                r.normal_x = -r.normal_x;
                r.normal_y = -r.normal_y;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(0, 2 * 65536 * 40)) - 65536 * 40;
        endcase
    endfunction

    function automatic scpn_req_t rnd_pair();
        scpn_req_t p;
        logic signed [31:0] cx, cy;
        p.start_x = rnd_coord(); p.start_y = rnd_coord();
        p.end_x = rnd_coord();   p.end_y = rnd_coord();
        p.wall_start_x = rnd_coord(); p.wall_start_y = rnd_coord();
        p.wall_end_x = rnd_coord();   p.wall_end_y = rnd_coord();
        if ($urandom_range(0, 99) < 65)
        begin
            cx = $signed($urandom_range(0, 65536 * 200)) - 65536 * 100;
            cy = $signed($urandom_range(0, 65536 * 200)) - 65536 * 100;
            p.start_x = cx - $signed($urandom_range(0, 1 << 22));
            p.end_x = cx + $signed($urandom_range(0, 1 << 22));
            p.start_y = cy - $signed($urandom_range(0, 1 << 22)) + (1 << 21);
            p.end_y = cy + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            p.wall_start_x = cx + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            p.wall_end_x = cx + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            p.wall_start_y = cy - $signed($urandom_range(0, 1 << 22));
            p.wall_end_y = cy + $signed($urandom_range(0, 1 << 22));
            if ($urandom_range(0, 1))
            begin
                p.start_x = p.end_x - p.start_x + p.end_x;
                {p.start_x, p.end_x} = {p.end_x, p.start_x};
            end
        end
        return p;
    endfunction

    function automatic scpn_req_t mk(int ax, int ay, int bx, int by, int ox, int oy,
        int px, int py);
        scpn_req_t p;
        p.start_x = ax; p.start_y = ay; p.end_x = bx; p.end_y = by;
        p.wall_start_x = ox; p.wall_start_y = oy; p.wall_end_x = px; p.wall_end_y = py;
        return p;
    endfunction

    initial
    begin
        localparam int U = 65536;
        scpn_req_t p;
        // plain crossing, both directions of motion
        pending_pairs.push_back(mk(-U, 0, U, 0, 0, -U, 0, U));
        pending_pairs.push_back(mk(U, 0, -U, 0, 0, -U, 0, U));
        // endpoint touching the wall, k = 0 and k = 1
        pending_pairs.push_back(mk(0, 0, U, U, 0, -U, 0, U));
        pending_pairs.push_back(mk(-U, U, 0, 0, -U, 0, U, 0));
        // miss, k beyond one
        pending_pairs.push_back(mk(-3 * U, 0, -2 * U, 0, 0, -U, 0, U));
        // collinear overlap, x axis, y axis, and zero-length motion
        pending_pairs.push_back(mk(-U, 0, U, 0, 0, 0, 2 * U, 0));
        pending_pairs.push_back(mk(0, -U, 0, U, 0, 0, 0, 2 * U));
        pending_pairs.push_back(mk(U, U, U, U, 0, 0, 2 * U, 2 * U));
        // collinear disjoint
        pending_pairs.push_back(mk(-3 * U, 0, -2 * U, 0, 0, 0, U, 0));
        // zero-length wall on the path
        pending_pairs.push_back(mk(-U, -U, U, U, 0, 0, 0, 0));
        // diagonal wall, odd normal
        pending_pairs.push_back(mk(0, 0, 3 * U, 7 * U, 0, 5 * U, 5 * U, 0));
        // coordinate extremes
        pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        pending_pairs.push_back(mk(32'h7fff_ffff, 0, 32'h8000_0000, 0, 0,
            32'h8000_0000, 0, 32'h7fff_ffff));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(mk(1, 0, -1, 0, 0, 1, 0, -1));
        for (int i = 0; i < 1540; i++)
        begin
            p = rnd_pair();
            pending_pairs.push_back(p);
        end
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (start && !busy)
                start <= 1'b0;
            if ((!start || !busy) && pending_pairs.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 34))
            begin
                req <= pending_pairs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            calm <= (n_sent >= 600 && n_sent < 900);
            if ((start && !busy) || done)
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (start && !busy)
            begin
                expected_hits.push_back(predict_collision(req));
                n_sent <= n_sent + 1;
            end
            if (done)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $realtime, rsp);
                    errors <= errors + 1;
                end
                else if (expected_hits[0] !== rsp)
                begin
                    $display("%0t: mismatch expected %p actual %p", $realtime,
                        expected_hits[0], rsp);
                    errors <= errors + 1;
                    void'(expected_hits.pop_front());
                end
                else
                begin
                    if (rsp.hit)
                        n_hits <= n_hits + 1;
                    void'(expected_hits.pop_front());
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_hits = 0;
        idle_cnt = 0;
        calm = 0;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while ((pending_pairs.size() > 0 || start || expected_hits.size() > 0)
            && idle_cnt < WATCHDOG)
            @(posedge clk);
        if (idle_cnt >= WATCHDOG)
        begin
            $display("Sent %0d segment pairs; %0d hits among the results checked.",
                n_sent, n_hits);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            repeat (60) @(posedge clk);
            $display("Sent %0d segment pairs; %0d hits among the results checked.",
                n_sent, n_hits);
            if (errors == 0 && expected_hits.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
